@@ rtl/rbd_pkg.sv @@
`default_nettype none

package rbd_pkg;

    // Default sizing
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;

    // Command codes (six and seven are no-ops)
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_INDEX = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ rtl/rbd_ram.sv @@
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ring_buffer_deque.sv @@
// Channel  | handshake           | payload
// ---------+---------------------+-----------------------------------------------
// input    | in_valid, in_ready  | command, value, index
// output   | out_valid, out_ready| status, front_value, back_value, read_value,
//          |                     | occupancy, is_empty, is_full
//
// One command per clock when the output is drained; each result passes through
// the store read stage, then the result register.
// Pointers and count update when a command is taken; the store is read once
// per command through its single registered read port.
// rst_n clears pointers, count and both valid stages; store contents are not reset.
// A stalled output holds the result and the read stage, then in_ready drops.
`default_nettype none

module ring_buffer_deque #(
    parameter int CAPACITY   = rbd_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = rbd_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [rbd_pkg::CMD_W-1:0]            command,
    input  wire logic signed [DATA_WIDTH-1:0]         value,
    input  wire logic [rbd_pkg::IDX_W-1:0]            index,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [rbd_pkg::STAT_W-1:0]                status,
    output logic signed [DATA_WIDTH-1:0]              front_value,
    output logic signed [DATA_WIDTH-1:0]              back_value,
    output logic signed [DATA_WIDTH-1:0]              read_value,
    output logic [$clog2(CAPACITY+1)-1:0]             occupancy,
    output logic                                      is_empty,
    output logic                                      is_full
);

    import rbd_pkg::*;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((PTR_W > IDX_W) ? PTR_W : IDX_W) + 1;
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // What the read stage must do to finish a transaction
    typedef enum logic [2:0] {
        FX_NONE,
        FX_PUSH_BACK,
        FX_PUSH_FRONT,
        FX_POP_BACK,
        FX_POP_FRONT,
        FX_READ_HIT,
        FX_READ_MISS
    } effect_t;

    typedef struct packed {
        effect_t                 effect;
        status_t                 stat;
        logic [DATA_WIDTH-1:0]   data;
        logic                    was_empty;
        logic [CNT_W-1:0]        count;
    } stage_t;

    // Architectural pointers and count
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Read stage
    logic   s1_valid_reg;
    stage_t s1_reg, s1_next;

    // End values, as of the last retired transaction
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;

    // Result register
    logic                  out_valid_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [DATA_WIDTH-1:0] front_out_reg, front_out_next;
    logic [DATA_WIDTH-1:0] back_out_reg, back_out_next;
    logic [DATA_WIDTH-1:0] read_out_reg, read_out_next;
    logic [CNT_W-1:0]      occ_reg;

    // Store ports
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic             accept;
    logic             s1_retire;
    logic             is_zero;
    logic             at_cap;
    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [SUM_W-1:0] idx_sum, idx_wrap;
    logic [PTR_W-1:0] idx_addr;
    logic             idx_hit;

    // Handshake
    assign s1_retire = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_retire;
    assign accept    = in_valid && in_ready;

    assign is_zero = (count_reg == '0);
    assign at_cap  = (count_reg == CNT_W'(CAPACITY));

    // Wrapping pointer neighbors
    assign head_inc = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(CAPACITY - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_W'(CAPACITY - 1) : tail_reg - 1'b1;

    // Logical index to slot; sum stays below twice the capacity when in range
    assign idx_sum  = SUM_W'(head_reg) + SUM_W'(index);
    assign idx_wrap = (idx_sum >= SUM_W'(CAPACITY)) ? idx_sum - SUM_W'(CAPACITY) : idx_sum;
    assign idx_addr = idx_wrap[PTR_W-1:0];
    assign idx_hit  = (CMP_W'(index) < CMP_W'(count_reg));

    // Command decode: pointer update, store access, read stage record
    always_comb
    begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        wr_en             = 1'b0;
        wr_addr           = tail_inc;
        rd_addr           = idx_addr;
        s1_next.effect    = FX_NONE;
        s1_next.stat      = STAT_OK;
        s1_next.data      = value;
        s1_next.was_empty = is_zero;

        unique case (cmd_t'(command)) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (at_cap)
                begin
                    s1_next.stat = STAT_OVERFLOW;
                end
                else if (is_zero)
                begin
                    head_next      = '0;
                    tail_next      = '0;
                    count_next     = CNT_W'(1);
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    s1_next.effect = FX_PUSH_BACK;
                end
                else if (cmd_t'(command) == CMD_PUSH_BACK)
                begin
                    tail_next      = tail_inc;
                    count_next     = count_reg + 1'b1;
                    wr_en          = 1'b1;
                    wr_addr        = tail_inc;
                    s1_next.effect = FX_PUSH_BACK;
                end
                else
                begin
                    head_next      = head_dec;
                    count_next     = count_reg + 1'b1;
                    wr_en          = 1'b1;
                    wr_addr        = head_dec;
                    s1_next.effect = FX_PUSH_FRONT;
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (is_zero)
                begin
                    s1_next.stat = STAT_UNDERFLOW;
                end
                else if (count_reg == CNT_W'(1))
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                else if (cmd_t'(command) == CMD_POP_BACK)
                begin
                    tail_next      = tail_dec;
                    count_next     = count_reg - 1'b1;
                    rd_addr        = tail_dec;
                    s1_next.effect = FX_POP_BACK;
                end
                else
                begin
                    head_next      = head_inc;
                    count_next     = count_reg - 1'b1;
                    rd_addr        = head_inc;
                    s1_next.effect = FX_POP_FRONT;
                end
            end
            CMD_READ_INDEX:
            begin
                if (idx_hit)
                begin
                    s1_next.effect = FX_READ_HIT;
                end
                else
                begin
                    s1_next.stat   = STAT_RANGE;
                    s1_next.effect = FX_READ_MISS;
                end
            end
            CMD_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase

        s1_next.count = count_next;
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Finish the transaction with the store data
    always_comb
    begin
        front_next    = front_reg;
        back_next     = back_reg;
        read_out_next = '0;

        case (s1_reg.effect)
            FX_PUSH_BACK:
            begin
                back_next = s1_reg.data;
                if (s1_reg.was_empty)
                begin
                    front_next = s1_reg.data;
                end
            end
            FX_PUSH_FRONT:
            begin
                front_next = s1_reg.data;
            end
            FX_POP_BACK:
            begin
                back_next = rd_data;
            end
            FX_POP_FRONT:
            begin
                front_next = rd_data;
            end
            FX_READ_HIT:
            begin
                read_out_next = rd_data;
            end
            FX_READ_MISS:
            begin
                read_out_next = s1_reg.was_empty ? '0 : back_reg;
            end
            default:
            begin
                read_out_next = '0;
            end
        endcase

        front_out_next = (s1_reg.count != '0) ? front_next : '0;
        back_out_next  = (s1_reg.count != '0) ? back_next : '0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_retire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_retire)
        begin
            front_reg     <= front_next;
            back_reg      <= back_next;
            status_reg    <= s1_reg.stat;
            front_out_reg <= front_out_next;
            back_out_reg  <= back_out_next;
            read_out_reg  <= read_out_next;
            occ_reg       <= s1_reg.count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign front_value = front_out_reg;
    assign back_value  = back_out_reg;
    assign read_value  = read_out_reg;
    assign occupancy   = occ_reg;
    assign is_empty    = (occ_reg == '0);
    assign is_full     = (occ_reg == CNT_W'(CAPACITY));

`ifndef SYNTHESIS
    // Count never runs past the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    // A push that fits grows the count by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !at_cap && (command == CMD_PUSH_BACK || command == CMD_PUSH_FRONT))
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow count");

    // A pop on an empty queue reports underflow
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_zero && (command == CMD_POP_BACK || command == CMD_POP_FRONT))
        |=> s1_reg.stat == STAT_UNDERFLOW)
        else $error("empty pop without underflow");

    // A stalled read stage keeps its transaction
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_retire) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("read stage lost a stalled transaction");
`endif

endmodule

`default_nettype wire
